/* rtl/drps_pkg.sv */
// ----------------------------------------------------------------------------
// drps_pkg
// Shared types and constants of the disk rotation pixel sampler.
// ----------------------------------------------------------------------------
package drps_pkg;

    localparam int IMAGE_SIDE  = 240;
    localparam int FRAC_BITS   = 14;
    localparam int CENTRE      = IMAGE_SIDE / 2;
    localparam int RADIUS_SQ   = CENTRE * CENTRE;
    localparam int STORE_DEPTH = IMAGE_SIDE * IMAGE_SIDE;

    localparam int COORD_W = 8;
    localparam int PIX_W   = 16;
    localparam int CFG_W   = 16;
    localparam int DELTA_W = COORD_W + 1;
    localparam int SQ_W    = 2 * DELTA_W;
    localparam int PROD_W  = DELTA_W + CFG_W;
    localparam int SUM_W   = PROD_W + 1;
    localparam int TRUNC_W = SUM_W - FRAC_BITS;
    localparam int SRC_W   = TRUNC_W + 1;
    localparam int ADDR_W  = $clog2(STORE_DEPTH);

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

    // words in flight: five front stages, the queue and the output stage
    localparam int INFLIGHT_W = 4;

    localparam logic signed [CFG_W-1:0] COS_RESET = CFG_W'(1 << FRAC_BITS);
    localparam logic signed [CFG_W-1:0] SIN_RESET = '0;

    typedef enum logic [0:0] {
        OP_LOAD   = 1'b0,
        OP_RENDER = 1'b1
    } drps_op_t;

    typedef enum logic [0:0] {
        CFG_COS = 1'b0,
        CFG_SIN = 1'b1
    } drps_cfg_idx_t;

    // one command from the front to the memory side
    typedef struct packed {
        drps_op_t          op;
        logic              ok;
        logic [ADDR_W-1:0] addr;
        logic [PIX_W-1:0]  data;
    } drps_cmd_t;

endpackage

/* rtl/drps_if.sv */
// ----------------------------------------------------------------------------
// drps_if
// Valid/ready channels of the disk rotation pixel sampler.
// ----------------------------------------------------------------------------
interface drps_item_if;
    import drps_pkg::*;

    logic               valid;
    logic               ready;
    drps_op_t           op;
    logic [COORD_W-1:0] pos_x;
    logic [COORD_W-1:0] pos_y;
    logic [PIX_W-1:0]   pixel_in;

    modport source (output valid, op, pos_x, pos_y, pixel_in, input ready);
    modport sink   (input valid, op, pos_x, pos_y, pixel_in, output ready);
endinterface

interface drps_result_if;
    import drps_pkg::*;

    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] pixel_out;
    logic             sampled;

    modport source (output valid, pixel_out, sampled, input ready);
    modport sink   (input valid, pixel_out, sampled, output ready);
endinterface

interface drps_cfg_if;
    import drps_pkg::*;

    logic             valid;
    logic             ready;
    drps_cfg_idx_t    index;
    logic [CFG_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

/* rtl/disk_rotation_pixel_sampler_core.sv */
// ----------------------------------------------------------------------------
// disk_rotation_pixel_sampler_core
// Nearest-neighbour rotating sampler of a square RGB565 image for a round
// display.
// ----------------------------------------------------------------------------
// The block takes one word per clock, loads and renders alike, unless a full
// queue stalls it, and returns one result per render, in order. A five stage
// address pipeline rotates the centre offsets and forms the row flipped store
// address; a four entry queue feeds the single port of the image store, which
// does one load or one render read each cycle, so that port sets the rate at
// one word per clock while the output stage takes renders. Loads and renders
// reach the store in the order they were taken, so a render sees every load
// taken before it. Store entries are undefined until loaded. The user must
// write the rotation registers only while no word is in flight; the block
// itself does not enforce it.
module disk_rotation_pixel_sampler_core (
    input  logic          clk,
    input  logic          rst_n,
    drps_item_if.sink     item,
    drps_cfg_if.sink      cfg,
    drps_result_if.source result
);
    import drps_pkg::*;

    logic      q_full;
    logic      q_push;
    logic      q_empty;
    logic      q_pop;
    drps_cmd_t q_cmd;
    drps_cmd_t q_head;

    drps_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item),
        .cfg    (cfg),
        .q_full (q_full),
        .q_push (q_push),
        .q_cmd  (q_cmd)
    );

    drps_fifo u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_cmd (q_cmd),
        .full     (q_full),
        .pop      (q_pop),
        .empty    (q_empty),
        .head     (q_head)
    );

    drps_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_empty (q_empty),
        .q_head  (q_head),
        .q_pop   (q_pop),
        .result  (result)
    );

endmodule

/* rtl/drps_front.sv */
// ----------------------------------------------------------------------------
// drps_front
// Accepts load and render words, holds the rotation registers and turns each
// word into a store command: five pipeline stages, stalled only by the queue.
// ----------------------------------------------------------------------------
module drps_front (
    input  logic                clk,
    input  logic                rst_n,
    drps_item_if.sink           item,
    drps_cfg_if.sink            cfg,
    input  logic                q_full,
    output logic                q_push,
    output drps_pkg::drps_cmd_t q_cmd
);
    import drps_pkg::*;

    logic signed [CFG_W-1:0] cos_reg;
    logic signed [CFG_W-1:0] sin_reg;

    logic adv;

    // stage a: input register
    logic               a_valid_reg;
    drps_op_t           a_op_reg;
    logic [COORD_W-1:0] a_x_reg;
    logic [COORD_W-1:0] a_y_reg;
    logic [PIX_W-1:0]   a_px_reg;

    // stage b: products and masks
    logic                     b_valid_reg;
    drps_op_t                 b_op_reg;
    logic                     b_ok_reg;
    logic [ADDR_W-1:0]        b_addr_reg;
    logic [PIX_W-1:0]         b_px_reg;
    logic signed [PROD_W-1:0] b_xc_reg;
    logic signed [PROD_W-1:0] b_ys_reg;
    logic signed [PROD_W-1:0] b_xs_reg;
    logic signed [PROD_W-1:0] b_yc_reg;

    // stage c: rotated sums
    logic                    c_valid_reg;
    drps_op_t                c_op_reg;
    logic                    c_ok_reg;
    logic [ADDR_W-1:0]       c_addr_reg;
    logic [PIX_W-1:0]        c_px_reg;
    logic signed [SUM_W-1:0] c_rx_reg;
    logic signed [SUM_W-1:0] c_ry_reg;

    // stage d: source coordinates
    logic               d_valid_reg;
    drps_op_t           d_op_reg;
    logic               d_ok_reg;
    logic [ADDR_W-1:0]  d_addr_reg;
    logic [PIX_W-1:0]   d_px_reg;
    logic [COORD_W-1:0] d_sx_reg;
    logic [COORD_W-1:0] d_sy_reg;

    // stage e: finished command
    logic      e_valid_reg;
    drps_cmd_t e_cmd_reg;

    logic signed [DELTA_W-1:0] dx;
    logic signed [DELTA_W-1:0] dy;
    logic signed [SQ_W-1:0]    dist_sq;
    logic                      in_square;
    logic                      in_disk;
    logic [ADDR_W-1:0]         load_addr;

    logic              rx_frac;
    logic              ry_frac;
    logic [SRC_W-1:0]  sx_full;
    logic [SRC_W-1:0]  sy_full;
    logic              src_ok;

    logic [COORD_W-1:0] flip_row;
    logic [ADDR_W-1:0]  render_addr;

    assign adv        = !e_valid_reg || !q_full;
    assign item.ready = adv;
    assign cfg.ready  = 1'b1;
    assign q_push     = e_valid_reg && !q_full;
    assign q_cmd      = e_cmd_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cos_reg <= COS_RESET;
            sin_reg <= SIN_RESET;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                CFG_COS: cos_reg <= cfg.data;
                CFG_SIN: sin_reg <= cfg.data;
                default: ;
            endcase
        end
    end

    // stage a -> b
    assign dx        = $signed({1'b0, a_x_reg} - DELTA_W'(CENTRE));
    assign dy        = $signed({1'b0, a_y_reg} - DELTA_W'(CENTRE));
    assign dist_sq   = SQ_W'(dx) * SQ_W'(dx) + SQ_W'(dy) * SQ_W'(dy);
    assign in_square = (a_x_reg < COORD_W'(IMAGE_SIDE)) && (a_y_reg < COORD_W'(IMAGE_SIDE));
    assign in_disk   = dist_sq <= SQ_W'(RADIUS_SQ);
    assign load_addr = ADDR_W'(a_y_reg) * ADDR_W'(IMAGE_SIDE) + ADDR_W'(a_x_reg);

    // stage c -> d: truncate toward zero, then re-centre
    assign rx_frac = c_rx_reg[SUM_W-1] && (c_rx_reg[FRAC_BITS-1:0] != '0);
    assign ry_frac = c_ry_reg[SUM_W-1] && (c_ry_reg[FRAC_BITS-1:0] != '0);
    assign sx_full = SRC_W'($signed(c_rx_reg[SUM_W-1:FRAC_BITS])) + SRC_W'(CENTRE)
                   + SRC_W'(rx_frac);
    assign sy_full = SRC_W'($signed(c_ry_reg[SUM_W-1:FRAC_BITS])) + SRC_W'(CENTRE)
                   + SRC_W'(ry_frac);
    assign src_ok  = !sx_full[SRC_W-1] && (sx_full[SRC_W-2:0] < (SRC_W-1)'(IMAGE_SIDE))
                  && !sy_full[SRC_W-1] && (sy_full[SRC_W-2:0] < (SRC_W-1)'(IMAGE_SIDE));

    // stage d -> e: row flipped store address
    assign flip_row    = COORD_W'(IMAGE_SIDE - 1) - d_sy_reg;
    assign render_addr = ADDR_W'(flip_row) * ADDR_W'(IMAGE_SIDE) + ADDR_W'(d_sx_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
            d_valid_reg <= 1'b0;
            e_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            a_valid_reg <= item.valid;
            b_valid_reg <= a_valid_reg;
            c_valid_reg <= b_valid_reg;
            d_valid_reg <= c_valid_reg;
            e_valid_reg <= d_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            a_op_reg <= item.op;
            a_x_reg  <= item.pos_x;
            a_y_reg  <= item.pos_y;
            a_px_reg <= item.pixel_in;

            b_op_reg   <= a_op_reg;
            b_ok_reg   <= in_square && ((a_op_reg == OP_LOAD) || in_disk);
            b_addr_reg <= load_addr;
            b_px_reg   <= a_px_reg;
            b_xc_reg   <= PROD_W'(dx) * PROD_W'(cos_reg);
            b_ys_reg   <= PROD_W'(dy) * PROD_W'(sin_reg);
            b_xs_reg   <= PROD_W'(dx) * PROD_W'(sin_reg);
            b_yc_reg   <= PROD_W'(dy) * PROD_W'(cos_reg);

            c_op_reg   <= b_op_reg;
            c_ok_reg   <= b_ok_reg;
            c_addr_reg <= b_addr_reg;
            c_px_reg   <= b_px_reg;
            c_rx_reg   <= SUM_W'(b_xc_reg) - SUM_W'(b_ys_reg);
            c_ry_reg   <= SUM_W'(b_xs_reg) + SUM_W'(b_yc_reg);

            d_op_reg   <= c_op_reg;
            d_ok_reg   <= c_ok_reg && ((c_op_reg == OP_LOAD) || src_ok);
            d_addr_reg <= c_addr_reg;
            d_px_reg   <= c_px_reg;
            d_sx_reg   <= sx_full[COORD_W-1:0];
            d_sy_reg   <= sy_full[COORD_W-1:0];

            e_cmd_reg.op   <= d_op_reg;
            e_cmd_reg.ok   <= d_ok_reg;
            e_cmd_reg.addr <= (d_op_reg == OP_LOAD) ? d_addr_reg : render_addr;
            e_cmd_reg.data <= d_px_reg;
        end
    end

endmodule

/* rtl/drps_fifo.sv */
// ----------------------------------------------------------------------------
// drps_fifo
// Short command queue between the address pipeline and the store side.
// ----------------------------------------------------------------------------
module drps_fifo (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  drps_pkg::drps_cmd_t push_cmd,
    output logic                full,
    input  logic                pop,
    output logic                empty,
    output drps_pkg::drps_cmd_t head
);
    import drps_pkg::*;

    drps_cmd_t               entry_reg [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0]   wr_ptr_reg;
    logic [FIFO_PTR_W-1:0]   rd_ptr_reg;
    logic [FIFO_CNT_W-1:0]   count_reg;
    logic [FIFO_CNT_W-1:0]   count_next;

    assign full  = count_reg == FIFO_CNT_W'(FIFO_DEPTH);
    assign empty = count_reg == '0;
    assign head  = entry_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_cmd;
    end

endmodule

/* rtl/drps_back.sv */
// ----------------------------------------------------------------------------
// drps_back
// Image store and output stage: carries out queued loads and renders in
// order through one memory port and holds the result word for the sink.
// ----------------------------------------------------------------------------
module drps_back (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                q_empty,
    input  drps_pkg::drps_cmd_t q_head,
    output logic                q_pop,
    drps_result_if.source       result
);
    import drps_pkg::*;

    logic [PIX_W-1:0] store [STORE_DEPTH];
    logic [PIX_W-1:0] rdata_reg;
    logic             out_valid_reg;
    logic             out_valid_next;
    logic             out_ok_reg;

    logic slot_free;
    logic wr_en;
    logic rd_en;
    logic take_render;

    // a load never waits on the output stage
    assign slot_free   = !out_valid_reg || result.ready;
    assign q_pop       = !q_empty && ((q_head.op == OP_LOAD) || slot_free);
    assign take_render = q_pop && (q_head.op == OP_RENDER);
    assign wr_en       = q_pop && (q_head.op == OP_LOAD) && q_head.ok;
    assign rd_en       = take_render && q_head.ok;

    assign result.valid     = out_valid_reg;
    assign result.sampled   = out_ok_reg;
    assign result.pixel_out = out_ok_reg ? rdata_reg : '0;

    always_comb
    begin
        out_valid_next = out_valid_reg && !result.ready;
        if (take_render)
            out_valid_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (take_render)
            out_ok_reg <= q_head.ok;
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            store[q_head.addr] <= q_head.data;
        if (rd_en)
            rdata_reg <= store[q_head.addr];
    end

endmodule

/* rtl/drps_checker.sv */
// ----------------------------------------------------------------------------
// drps_checker
// Port level checks of the sampler, bound to the top level.
// ----------------------------------------------------------------------------
module drps_checker (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         item_valid,
    input logic                         item_ready,
    input drps_pkg::drps_op_t           item_op,
    input logic                         out_valid,
    input logic                         out_ready,
    input logic [drps_pkg::PIX_W-1:0]   pixel_out,
    input logic                         sampled
);
    import drps_pkg::*;

    logic [INFLIGHT_W-1:0] pend_reg;
    logic [INFLIGHT_W-1:0] pend_next;
    logic                  render_in;
    logic                  word_out;

    assign render_in = item_valid && item_ready && (item_op == OP_RENDER);
    assign word_out  = out_valid && out_ready;

    always_comb
    begin
        pend_next = pend_reg;
        if (render_in && !word_out)
            pend_next = pend_reg + 1'b1;
        else if (word_out && !render_in)
            pend_next = pend_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pend_reg <= '0;
        else
            pend_reg <= pend_next;
    end

    // a result only for a render still owed
    a_no_extra_result: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> pend_reg != '0)
        else $error("result word with no render outstanding");

    a_masked_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !sampled |-> pixel_out == '0)
        else $error("masked pixel is not zero");

    a_valid_holds: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result valid dropped while stalled");

    a_payload_holds: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(pixel_out) && $stable(sampled))
        else $error("result word changed while stalled");

endmodule

bind disk_rotation_pixel_sampler_core drps_checker u_drps_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (item.valid),
    .item_ready (item.ready),
    .item_op    (item.op),
    .out_valid  (result.valid),
    .out_ready  (result.ready),
    .pixel_out  (result.pixel_out),
    .sampled    (result.sampled)
);

/* tb/testbench.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the disk rotation pixel sampler. Loads and renders
// go through the item channel with random gaps on both sides. A local copy of
// the image store and of the rotation registers predicts every render result.
// A short table of directed words comes first, then random phases under
// several rotation settings.
// ----------------------------------------------------------------------------
module testbench;
    import drps_pkg::*;

    localparam int     CYCLE_LIMIT     = 500000;
    localparam int     PHASES          = 12;
    localparam int     ITEMS_PER_PHASE = 50;
    localparam int     DIRECTED_ROWS   = 23;
    localparam int     IDLE_TAIL       = 16;
    localparam longint FRAC_SCALE      = longint'(1) << FRAC_BITS;

    typedef struct packed {
        logic [PIX_W-1:0] pixel;
        logic             sampled;
    } pixel_result_t;

    typedef struct {
        bit            from_store;
        int unsigned   addr;
        pixel_result_t res;
    } sample_t;

    typedef struct {
        drps_op_t           op;
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [PIX_W-1:0]   pix;
        bit                 known;
        logic [PIX_W-1:0]   exp_pix;
        logic               exp_sampled;
    } stim_row_t;

    logic clk = 1'b0;
    logic rst_n;

    drps_item_if   item_ch ();
    drps_cfg_if    cfg_ch ();
    drps_result_if res_ch ();

    disk_rotation_pixel_sampler_core dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_ch),
        .cfg    (cfg_ch),
        .result (res_ch)
    );

    always #1 clk = ~clk;

    // local copy of the block state
    logic [PIX_W-1:0]        image_copy [STORE_DEPTH];
    bit                      loaded_mask [STORE_DEPTH];
    logic signed [CFG_W-1:0] cos_reg;
    logic signed [CFG_W-1:0] sin_reg;

    pixel_result_t pending_pixels [$];
    int            err_count   = 0;
    int unsigned   cycle_count = 0;
    int            rx_hold     = 0;
    bit            steady      = 1'b0;

    logic [CFG_W-1:0] phase_cos [PHASES];
    logic [CFG_W-1:0] phase_sin [PHASES];

    stim_row_t directed_rows [DIRECTED_ROWS] = '{
        '{OP_LOAD,   8'd120, 8'd119, 16'hFFFF, 1'b0, 16'h0000, 1'b0},
        '{OP_RENDER, 8'd120, 8'd120, 16'hDEAD, 1'b1, 16'hFFFF, 1'b1},
        '{OP_LOAD,   8'd0,   8'd119, 16'h0000, 1'b0, 16'h0000, 1'b0},
        '{OP_RENDER, 8'd0,   8'd120, 16'hDEAD, 1'b1, 16'h0000, 1'b1},
        '{OP_LOAD,   8'd239, 8'd119, 16'hA5A5, 1'b0, 16'h0000, 1'b0},
        '{OP_RENDER, 8'd239, 8'd120, 16'hDEAD, 1'b1, 16'hA5A5, 1'b1},
        '{OP_LOAD,   8'd120, 8'd239, 16'h5A5A, 1'b0, 16'h0000, 1'b0},
        '{OP_RENDER, 8'd120, 8'd0,   16'hDEAD, 1'b1, 16'h5A5A, 1'b1},
        '{OP_LOAD,   8'd120, 8'd0,   16'h8001, 1'b0, 16'h0000, 1'b0},
        '{OP_RENDER, 8'd120, 8'd239, 16'hDEAD, 1'b1, 16'h8001, 1'b1},
        // corners and the first pixel past the rim
        '{OP_RENDER, 8'd0,   8'd0,   16'hFFFF, 1'b1, 16'h0000, 1'b0},
        '{OP_RENDER, 8'd239, 8'd239, 16'h0000, 1'b1, 16'h0000, 1'b0},
        '{OP_RENDER, 8'd0,   8'd121, 16'hDEAD, 1'b1, 16'h0000, 1'b0},
        // outside the display square
        '{OP_RENDER, 8'd240, 8'd120, 16'hDEAD, 1'b1, 16'h0000, 1'b0},
        '{OP_RENDER, 8'd120, 8'd255, 16'hDEAD, 1'b1, 16'h0000, 1'b0},
        // loads outside the image are dropped
        '{OP_LOAD,   8'd255, 8'd0,   16'h1234, 1'b0, 16'h0000, 1'b0},
        '{OP_LOAD,   8'd7,   8'd240, 16'h4321, 1'b0, 16'h0000, 1'b0},
        // overwrite right before the read
        '{OP_LOAD,   8'd120, 8'd119, 16'h7FFE, 1'b0, 16'h0000, 1'b0},
        '{OP_RENDER, 8'd120, 8'd120, 16'hDEAD, 1'b1, 16'h7FFE, 1'b1},
        '{OP_RENDER, 8'd60,  8'd70,  16'h0F0F, 1'b0, 16'h0000, 1'b0},
        '{OP_RENDER, 8'd200, 8'd150, 16'hF0F0, 1'b0, 16'h0000, 1'b0},
        '{OP_LOAD,   8'd255, 8'd255, 16'hFFFF, 1'b0, 16'h0000, 1'b0},
        '{OP_RENDER, 8'd255, 8'd0,   16'hDEAD, 1'b1, 16'h0000, 1'b0}
    };

    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return $urandom_range(1, 3);
        if (r < 95)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic sample_t predict_pixel(input logic [COORD_W-1:0] x,
                                              input logic [COORD_W-1:0] y);
        sample_t s;
        longint  dx, dy, sx, sy, c, sn;
        s.from_store = 1'b0;
        s.addr       = 0;
        s.res        = '0;
        if (x >= IMAGE_SIDE || y >= IMAGE_SIDE)
            return s;
        dx = x;
        dy = y;
        dx = dx - CENTRE;
        dy = dy - CENTRE;
        if (dx * dx + dy * dy > RADIUS_SQ)
            return s;
        c  = cos_reg;
        sn = sin_reg;
        // signed division truncates toward zero
        sx = CENTRE + (dx * c - dy * sn) / FRAC_SCALE;
        sy = CENTRE + (dx * sn + dy * c) / FRAC_SCALE;
        if (sx < 0 || sx >= IMAGE_SIDE || sy < 0 || sy >= IMAGE_SIDE)
            return s;
        s.from_store  = 1'b1;
        s.addr        = int'((IMAGE_SIDE - 1 - sy) * IMAGE_SIDE + sx);
        s.res.pixel   = image_copy[s.addr];
        s.res.sampled = 1'b1;
        return s;
    endfunction

    task automatic drive_word(input drps_op_t op, input logic [COORD_W-1:0] x,
                              input logic [COORD_W-1:0] y, input logic [PIX_W-1:0] pix);
        int          gap;
        int unsigned idx;
        gap = (!steady && $urandom_range(0, 2) == 0) ? idle_len() : 0;
        if (gap > 0)
        begin
            item_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_ch.valid    <= 1'b1;
        item_ch.op       <= op;
        item_ch.pos_x    <= x;
        item_ch.pos_y    <= y;
        item_ch.pixel_in <= pix;
        do @(posedge clk); while (!item_ch.ready);
        if (op == OP_LOAD && x < IMAGE_SIDE && y < IMAGE_SIDE)
        begin
            idx              = int'(y) * IMAGE_SIDE + int'(x);
            image_copy[idx]  = pix;
            loaded_mask[idx] = 1'b1;
        end
    endtask

    task automatic render_word(input logic [COORD_W-1:0] x, input logic [COORD_W-1:0] y,
                               input logic [PIX_W-1:0] pix, input bit known,
                               input pixel_result_t typed);
        sample_t s;
        s = predict_pixel(x, y);
        // never read an entry that was not loaded: load it just ahead
        if (s.from_store && !loaded_mask[s.addr])
            drive_word(OP_LOAD, COORD_W'(s.addr % IMAGE_SIDE), COORD_W'(s.addr / IMAGE_SIDE),
                       PIX_W'($urandom));
        drive_word(OP_RENDER, x, y, pix);
        s = predict_pixel(x, y);
        pending_pixels.push_back(known ? typed : s.res);
    endtask

    task automatic write_rotation(input logic [CFG_W-1:0] c, input logic [CFG_W-1:0] s);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= CFG_COS;
        cfg_ch.data  <= c;
        do @(posedge clk); while (!cfg_ch.ready);
        cos_reg = c;
        cfg_ch.index <= CFG_SIN;
        cfg_ch.data  <= s;
        do @(posedge clk); while (!cfg_ch.ready);
        sin_reg = s;
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic drain_pipeline(input int tail);
        item_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending_pixels.size() != 0)
            @(posedge clk);
        repeat (tail) @(posedge clk);
    endtask

    // result side: random back-pressure
    always @(posedge clk)
    begin
        if (rx_hold > 0)
            rx_hold--;
        else if (!steady && $urandom_range(0, 4) == 0)
            rx_hold = idle_len();
        res_ch.ready <= (rx_hold == 0);
    end

    always @(posedge clk)
    begin
        pixel_result_t want;
        if (rst_n && res_ch.valid && res_ch.ready)
        begin
            if (pending_pixels.size() == 0)
            begin
                $display("%0t unexpected result: expected none, actual pixel_out %h sampled %b",
                         $time, res_ch.pixel_out, res_ch.sampled);
                err_count++;
            end
            else
            begin
                want = pending_pixels.pop_front();
                if (res_ch.pixel_out !== want.pixel)
                begin
                    $display("%0t pixel_out mismatch: expected %h actual %h",
                             $time, want.pixel, res_ch.pixel_out);
                    err_count++;
                end
                if (res_ch.sampled !== want.sampled)
                begin
                    $display("%0t sampled mismatch: expected %b actual %b",
                             $time, want.sampled, res_ch.sampled);
                    err_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("%0t timeout with %0d results outstanding", $time, pending_pixels.size());
            $display("simulation failed");
            $finish;
        end
    end

    initial
    begin
        int               r;
        int               v;
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        pixel_result_t    typed;

        rst_n            = 1'b0;
        item_ch.valid    = 1'b0;
        item_ch.op       = OP_LOAD;
        item_ch.pos_x    = '0;
        item_ch.pos_y    = '0;
        item_ch.pixel_in = '0;
        cfg_ch.valid     = 1'b0;
        cfg_ch.index     = CFG_COS;
        cfg_ch.data      = '0;
        res_ch.ready     = 1'b0;
        cos_reg          = COS_RESET;
        sin_reg          = SIN_RESET;
        foreach (loaded_mask[i])
        begin
            loaded_mask[i] = 1'b0;
            image_copy[i]  = '0;
        end

        phase_cos[0]  = 16'h4000;  phase_sin[0]  = 16'h0000;
        phase_cos[1]  = 16'h0000;  phase_sin[1]  = 16'h4000;
        phase_cos[2]  = 16'hC000;  phase_sin[2]  = 16'h0000;
        phase_cos[3]  = 16'h0000;  phase_sin[3]  = 16'hC000;
        phase_cos[4]  = 16'h2D41;  phase_sin[4]  = 16'h2D41;
        phase_cos[5]  = 16'hD2BF;  phase_sin[5]  = 16'h2D41;
        phase_cos[6]  = 16'h4000;  phase_sin[6]  = 16'h4000;
        phase_cos[7]  = 16'hC000;  phase_sin[7]  = 16'hC000;
        // raw extremes, no clamping in the block
        phase_cos[8]  = 16'h7FFF;  phase_sin[8]  = 16'h8000;
        for (int p = 9; p < 11; p++)
        begin
            v            = int'($urandom_range(0, 32768)) - 16384;
            phase_cos[p] = CFG_W'(v);
            v            = int'($urandom_range(0, 32768)) - 16384;
            phase_sin[p] = CFG_W'(v);
        end
        phase_cos[11] = CFG_W'($urandom);
        phase_sin[11] = CFG_W'($urandom);

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        write_rotation(16'h4000, 16'h0000);

        foreach (directed_rows[i])
        begin
            typed = {directed_rows[i].exp_pix, directed_rows[i].exp_sampled};
            if (directed_rows[i].op == OP_LOAD)
                drive_word(OP_LOAD, directed_rows[i].x, directed_rows[i].y, directed_rows[i].pix);
            else
                render_word(directed_rows[i].x, directed_rows[i].y, directed_rows[i].pix,
                            directed_rows[i].known, typed);
        end

        for (int p = 0; p < PHASES; p++)
        begin
            drain_pipeline(IDLE_TAIL);
            write_rotation(phase_cos[p], phase_sin[p]);
            steady = (p == 2) || ($urandom_range(0, 4) == 0);
            for (int n = 0; n < ITEMS_PER_PHASE; n++)
            begin
                // hold the sender until every pending render result has come back
                if (n == ITEMS_PER_PHASE / 2 && p % 4 == 1)
                    drain_pipeline(0);
                r = $urandom_range(0, 99);
                if (r < 30)
                    drive_word(OP_LOAD, COORD_W'($urandom_range(0, IMAGE_SIDE - 1)),
                               COORD_W'($urandom_range(0, IMAGE_SIDE - 1)), PIX_W'($urandom));
                else if (r < 80)
                    render_word(COORD_W'($urandom_range(0, IMAGE_SIDE - 1)),
                                COORD_W'($urandom_range(0, IMAGE_SIDE - 1)),
                                PIX_W'($urandom), 1'b0, '0);
                else if (r < 90)
                    drive_word(OP_LOAD, COORD_W'($urandom), COORD_W'($urandom), PIX_W'($urandom));
                else
                begin
                    x = COORD_W'($urandom);
                    y = COORD_W'($urandom);
                    render_word(x, y, PIX_W'($urandom), 1'b0, '0);
                end
            end
        end

        steady = 1'b0;
        drain_pipeline(20);
        if (err_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
